FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. They compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge, held off while reset is high.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: rtl/core/sne_pkg.sv
package sne_pkg;

  // Fixed field widths.
  localparam int ELEM_W = 6;
  localparam int MASK_W = 64;
  localparam int ORD_W  = 7;
  localparam int FUNC_W = 2;

  // Input item function codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_PROD   = 2'd0,
    FN_INV    = 2'd1,
    FN_SUBSET = 2'd2,
    FN_RUN    = 2'd3
  } func_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_MEMB,
    S_PROD1,
    S_PROD2,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // apply a table or subset write
    logic run_start;   // latch order and subset, seed result with H
    logic cand_next;   // skip to the next candidate
    logic cand_pass;   // candidate joins the result, move on
    logic cand_begin;  // fetch inverse of candidate, rewind member
    logic memb_next;   // move to the next member
    logic prod1_rd;    // read candidate * member
    logic prod2_rd;    // read (candidate * member) * candidate^-1
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cand_done;   // all candidates walked
    logic cand_in_res; // candidate already in the result
    logic memb_done;   // all members walked
    logic memb_in_h;   // member belongs to H
    logic t_ok;        // first product and inverse lie in the group
    logic c_ok;        // conjugate lies in H
    logic out_free;    // output register can take a new result
  } stat_t;

endpackage

FILE: rtl/core/sne_ctrl.sv
module sne_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     func,
  output logic           in_ready,
  input  sne_pkg::stat_t stat,
  output sne_pkg::cmd_t  cmd
);
  import sne_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (func == FN_RUN)) state_next = S_CAND;
      end
      S_CAND: begin
        priority if (stat.cand_done) state_next = S_DONE;
        else if (stat.cand_in_res)    state_next = S_CAND;
        else                          state_next = S_MEMB;
      end
      S_MEMB: begin
        priority if (stat.memb_done) state_next = S_CAND;
        else if (stat.memb_in_h)     state_next = S_PROD1;
        else                         state_next = S_MEMB;
      end
      S_PROD1: begin
        state_next = stat.t_ok ? S_PROD2 : S_CAND;
      end
      S_PROD2: begin
        state_next = stat.c_ok ? S_MEMB : S_CAND;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load      = accept && (func != FN_RUN);
        cmd.run_start = accept && (func == FN_RUN);
      end
      S_CAND: begin
        priority if (stat.cand_done) cmd = '0;
        else if (stat.cand_in_res)    cmd.cand_next  = 1'b1;
        else                          cmd.cand_begin = 1'b1;
      end
      S_MEMB: begin
        priority if (stat.memb_done) cmd.cand_pass = 1'b1;
        else if (stat.memb_in_h)     cmd.prod1_rd  = 1'b1;
        else                         cmd.memb_next = 1'b1;
      end
      S_PROD1: begin
        if (stat.t_ok) cmd.prod2_rd  = 1'b1;
        else           cmd.cand_next = 1'b1;
      end
      S_PROD2: begin
        if (stat.c_ok) cmd.memb_next = 1'b1;
        else           cmd.cand_next = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

`include "assert_macros.svh"
  `ASSERT_PROP(a_run_enters_walk, clk, rst, (accept && (func == FN_RUN)) |=> (state == S_CAND))
  `ASSERT_PROP(a_cand_cmd_onehot, clk, rst, $onehot0({cmd.cand_next, cmd.cand_pass, cmd.cand_begin}))
  `ASSERT_PROP(a_pass_after_members, clk, rst, cmd.cand_pass |-> stat.memb_done)

endmodule

FILE: rtl/core/sne_datapath.sv
module sne_datapath #(
  parameter int MAX_ORDER = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sne_pkg::ORD_W-1:0]   cfg_wdata,
  input  logic [sne_pkg::FUNC_W-1:0]  func,
  input  logic [sne_pkg::ELEM_W-1:0]  row_elem,
  input  logic [sne_pkg::ELEM_W-1:0]  col_elem,
  input  logic [sne_pkg::ELEM_W-1:0]  value_elem,
  input  logic                        member_bit,
  input  sne_pkg::cmd_t               cmd,
  output sne_pkg::stat_t              stat,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [sne_pkg::MASK_W-1:0]  normalizer_mask
);
  import sne_pkg::*;

  localparam int IDX_W      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W      = $clog2(MAX_ORDER + 1);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int PROD_DEPTH = 1 << ADDR_W;

  logic [ORD_W-1:0]  group_order;
  logic [CNT_W-1:0]  n;
  logic [MASK_W-1:0] subset_mask;
  logic [MASK_W-1:0] hmask;
  logic [MASK_W-1:0] res;
  logic [CNT_W-1:0]  cand;
  logic [CNT_W-1:0]  member;
  logic [ELEM_W-1:0] prod_q;
  logic [ELEM_W-1:0] inv_q;

  logic [ELEM_W-1:0] prod_mem [PROD_DEPTH];
  logic [ELEM_W-1:0] inv_mem  [MAX_ORDER];

  logic [ORD_W-1:0]  n_clamp;
  logic [MASK_W-1:0] low_mask;
  logic [ORD_W-1:0]  n_ext;
  logic              row_ok;
  logic              col_ok;
  logic [ADDR_W-1:0] prod_rd_addr;

  // Effective order and the mask of elements below it.
  always_comb begin
    priority if (group_order == '0) n_clamp = ORD_W'(1);
    else if (group_order > ORD_W'(MAX_ORDER)) n_clamp = ORD_W'(MAX_ORDER);
    else n_clamp = group_order;
    for (int k = 0; k < MASK_W; k++) begin
      low_mask[k] = (ORD_W'(k) < n_clamp);
    end
  end

  assign n_ext  = ORD_W'(n);
  assign row_ok = (ORD_W'(row_elem) < ORD_W'(MAX_ORDER));
  assign col_ok = (ORD_W'(col_elem) < ORD_W'(MAX_ORDER));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_order <= ORD_W'(1);
    end else if (cfg_we) begin
      group_order <= cfg_wdata;
    end
  end

  // Subset membership bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      subset_mask <= '0;
    end else if (cmd.load && (func == FN_SUBSET) && row_ok) begin
      subset_mask[row_elem] <= member_bit;
    end
  end

  // Product table: written by loads, one registered read port for the walk.
  assign prod_rd_addr = cmd.prod1_rd ? {cand[IDX_W-1:0], member[IDX_W-1:0]}
                                     : {prod_q[IDX_W-1:0], inv_q[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.load && (func == FN_PROD) && row_ok && col_ok) begin
      prod_mem[{row_elem[IDX_W-1:0], col_elem[IDX_W-1:0]}] <= value_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod1_rd || cmd.prod2_rd) begin
      prod_q <= prod_mem[prod_rd_addr];
    end
  end

  // Inverse table, read once per candidate tested.
  always_ff @(posedge clk) begin
    if (cmd.load && (func == FN_INV) && row_ok) begin
      inv_mem[row_elem[IDX_W-1:0]] <= value_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_begin) begin
      inv_q <= inv_mem[cand[IDX_W-1:0]];
    end
  end

  // Run state: order, H, result and the two walk counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      n      <= CNT_W'(1);
      hmask  <= '0;
      res    <= '0;
      cand   <= '0;
      member <= '0;
    end else begin
      if (cmd.run_start) begin
        n      <= CNT_W'(n_clamp);
        hmask  <= subset_mask & low_mask;
        res    <= subset_mask & low_mask;
        cand   <= '0;
        member <= '0;
      end
      if (cmd.cand_next) begin
        cand <= cand + CNT_W'(1);
      end
      if (cmd.cand_pass) begin
        res[ELEM_W'(cand)] <= 1'b1;
        cand               <= cand + CNT_W'(1);
      end
      if (cmd.cand_begin) begin
        member <= '0;
      end
      if (cmd.memb_next) begin
        member <= member + CNT_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      normalizer_mask <= res;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.cand_done   = (cand == n);
    stat.cand_in_res = res[ELEM_W'(cand)];
    stat.memb_done   = (member == n);
    stat.memb_in_h   = hmask[ELEM_W'(member)];
    stat.t_ok        = (ORD_W'(prod_q) < n_ext) && (ORD_W'(inv_q) < n_ext);
    stat.c_ok        = (ORD_W'(prod_q) < n_ext) && hmask[prod_q];
    stat.out_free    = !out_valid || out_ready;
  end

`include "assert_macros.svh"
  `ASSERT_PROP(a_res_covers_h, clk, rst, ((res & hmask) == hmask))
  `ASSERT_PROP(a_cand_bounded, clk, rst, (cand <= n))
  `ASSERT_NEVER(a_out_overwrite, clk, rst, cmd.out_load && out_valid && !out_ready)

endmodule

FILE: rtl/core/subgroup_normalizer_engine_unit.sv
// Normalizer engine for a subset H of a finite group of up to MAX_ORDER
// elements, element 0 being the identity. Load items (product entry,
// inverse entry, subset bit) are taken one per cycle while the block is
// idle and produce no result. A run item seeds the result with H and then
// walks every candidate h not yet in it; for each member g of H it reads
// h*g and then (h*g)*h^-1 from the single read port of the product table,
// and early exit on the first failing member shortens the run. The answer
// leaves as one 64-bit mask; no new item is taken while a run is under way,
// but loads are taken while the previous answer still waits for its
// transfer. Table entries hold garbage until written; group_order is to be
// written only while the block is idle, a rule for the user that the block
// itself does not enforce.
module subgroup_normalizer_engine_unit #(
  parameter int MAX_ORDER = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sne_pkg::ORD_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sne_pkg::FUNC_W-1:0]  func,
  input  logic [sne_pkg::ELEM_W-1:0]  row_elem,
  input  logic [sne_pkg::ELEM_W-1:0]  col_elem,
  input  logic [sne_pkg::ELEM_W-1:0]  value_elem,
  input  logic                        member_bit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sne_pkg::MASK_W-1:0]  normalizer_mask
);
  import sne_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer for loads and the candidate/member walk.
  sne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tables, masks, counters and the output register.
  sne_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .func            (func),
    .row_elem        (row_elem),
    .col_elem        (col_elem),
    .value_elem      (value_elem),
    .member_bit      (member_bit),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .normalizer_mask (normalizer_mask)
  );

endmodule

FILE: tb/tb_subgroup_normalizer_engine_unit.sv
module tb_subgroup_normalizer_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sne_pkg::*;

  localparam int ORDER_MAX   = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LOAD_SETTLE = 8;
  localparam int END_DRAIN   = 16;
  localparam int LONG_HOLD   = 3000;

  // Shapes of the group tables that a phase loads.
  typedef enum int {
    GK_CYCLIC,
    GK_DIHEDRAL,
    GK_XOR,
    GK_CORRUPT,
    GK_GARBAGE
  } grp_kind_t;

  typedef struct {
    func_t             fn;
    logic [ELEM_W-1:0] row;
    logic [ELEM_W-1:0] col;
    logic [ELEM_W-1:0] val;
    logic              mbit;
  } sne_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [ORD_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   func = '0;
  logic [ELEM_W-1:0]   row_elem = '0;
  logic [ELEM_W-1:0]   col_elem = '0;
  logic [ELEM_W-1:0]   value_elem = '0;
  logic                member_bit = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [MASK_W-1:0]   normalizer_mask;

  subgroup_normalizer_engine_unit dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .row_elem        (row_elem),
    .col_elem        (col_elem),
    .value_elem      (value_elem),
    .member_bit      (member_bit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .normalizer_mask (normalizer_mask)
  );

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow state of the engine, updated on every accepted transfer.
  logic [ELEM_W-1:0] prod_shadow [0:ORDER_MAX*ORDER_MAX-1];
  logic [ELEM_W-1:0] inv_shadow [0:ORDER_MAX-1];
  logic [MASK_W-1:0] subset_shadow = '0;
  logic [ORD_W-1:0]  order_shadow = 7'd1;
  logic [MASK_W-1:0] pending_norms [$];
  logic [MASK_W-1:0] want_mask;
  int unsigned       norm_errors = 0;

  // Tables of the group being built, and the subset as the engine will hold it.
  logic [ELEM_W-1:0] grp_prod [0:ORDER_MAX*ORDER_MAX-1];
  logic [ELEM_W-1:0] grp_inv [0:ORDER_MAX-1];
  logic [MASK_W-1:0] grp_subset = '0;

  // Sender and receiver bookkeeping.
  sne_item_t   item_queue [$];
  sne_item_t   cur_item;
  bit          drv_busy = 1'b0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned in_gap_max = 14;
  int unsigned out_gap_max = 14;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned items_pushed = 0;
  int unsigned runs_pushed = 0;
  int unsigned cycle_count = 0;

  // True when h*g*h^-1 stays inside the group and lands in H.
  function automatic bit conj_stays_in_h(int h, int g, int n, logic [MASK_W-1:0] hm);
    int t, hi, c;
    t  = prod_shadow[h*ORDER_MAX + g];
    hi = inv_shadow[h];
    if (t >= n || hi >= n) return 1'b0;
    c = prod_shadow[t*ORDER_MAX + hi];
    if (c >= n) return 1'b0;
    return hm[c];
  endfunction

  // Normalizer of the current subset under the current order.
  function automatic logic [MASK_W-1:0] predicted_normalizer();
    int n;
    bit all_in;
    logic [MASK_W-1:0] hm, res;
    n = order_shadow;
    if (n < 1) n = 1;
    if (n > ORDER_MAX) n = ORDER_MAX;
    hm = (n >= 64) ? subset_shadow : subset_shadow & ((64'd1 << n) - 64'd1);
    res = hm;
    for (int h = 0; h < n; h++) begin
      if (res[h]) continue;
      all_in = 1'b1;
      for (int g = 0; g < n && all_in; g++) begin
        if (hm[g] && !conj_stays_in_h(h, g, n, hm)) all_in = 1'b0;
      end
      if (all_in) res[h] = 1'b1;
    end
    return res;
  endfunction

  function automatic void track_item(func_t f, logic [ELEM_W-1:0] r, logic [ELEM_W-1:0] c,
                                     logic [ELEM_W-1:0] v, logic b);
    case (f)
      FN_PROD:   prod_shadow[{r, c}] = v;
      FN_INV:    inv_shadow[r] = v;
      FN_SUBSET: subset_shadow[r] = b;
      FN_RUN:    pending_norms.push_back(predicted_normalizer());
      default:   ;
    endcase
  endfunction

  function automatic void flag_error(string what, logic [MASK_W-1:0] got,
                                     logic [MASK_W-1:0] exp_val);
    norm_errors++;
    if (norm_errors <= 10) begin
      $display("ERROR %s: got %h, expected %h", what, got, exp_val);
    end
  endfunction

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      track_item(func_t'(func), row_elem, col_elem, value_elem, member_bit);
      in_taken = 1'b1;
    end
    if (!rst && out_valid && out_ready) begin
      out_taken = 1'b1;
      if (pending_norms.size() == 0) begin
        flag_error("result with nothing pending", normalizer_mask, '0);
      end else begin
        want_mask = pending_norms.pop_front();
        if (normalizer_mask !== want_mask) begin
          flag_error("normalizer mask", normalizer_mask, want_mask);
        end
      end
    end
  end

  // Sender: takes the next item, idles for its drawn gap, then holds it until the transfer.
  always @(negedge clk) begin
    if (in_taken) begin
      in_taken = 1'b0;
      drv_busy = 1'b0;
    end
    if (!drv_busy && item_queue.size() != 0) begin
      cur_item = item_queue.pop_front();
      in_wait = $urandom_range(0, in_gap_max);
      drv_busy = 1'b1;
    end
    if (drv_busy && in_wait == 0) begin
      in_valid   <= 1'b1;
      func       <= cur_item.fn;
      row_elem   <= cur_item.row;
      col_elem   <= cur_item.col;
      value_elem <= cur_item.val;
      member_bit <= cur_item.mbit;
    end else begin
      if (in_wait != 0) in_wait--;
      in_valid <= 1'b0;
    end
  end

  // Receiver: stalls each result for a drawn number of cycles, or for a long hold on request.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait = $urandom_range(0, out_gap_max);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_valid && out_wait != 0) begin
      out_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("subgroup_normalizer_engine_unit: mismatch");
    $finish;
  end

  function automatic int any_elem();
    return $urandom_range(0, 63);
  endfunction

  function automatic void push_item(func_t fn, int row, int col, int val, bit mbit);
    sne_item_t it;
    it.fn   = fn;
    it.row  = ELEM_W'(row);
    it.col  = ELEM_W'(col);
    it.val  = ELEM_W'(val);
    it.mbit = mbit;
    item_queue.push_back(it);
    items_pushed++;
    if (fn == FN_RUN) runs_pushed++;
    if (fn == FN_SUBSET) grp_subset[it.row] = mbit;
  endfunction

  function automatic grp_kind_t pick_kind(int n);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return GK_CYCLIC;
    if (r < 6) return (n % 2 == 0) ? GK_DIHEDRAL : GK_CYCLIC;
    if (r < 7 && (n & (n - 1)) == 0) return GK_XOR;
    if (r < 9) return GK_CORRUPT;
    return GK_GARBAGE;
  endfunction

  // Fills the product and inverse tables for elements below n.
  function automatic void build_group(grp_kind_t kind, int n);
    int m, ia, ib, ja, jb, ic, top;
    m = (n > 1) ? n / 2 : 1;
    top = (n < 60) ? n + 3 : 63;
    for (int a = 0; a < n; a++) begin
      ia = a % m;
      ja = a / m;
      for (int b = 0; b < n; b++) begin
        ib = b % m;
        jb = b / m;
        case (kind)
          GK_DIHEDRAL: begin
            // (r^ia s^ja)(r^ib s^jb) = r^(ia +/- ib) s^(ja + jb)
            ic = ja ? (ia - ib + m) % m : (ia + ib) % m;
            grp_prod[a*ORDER_MAX + b] = ELEM_W'((ja ^ jb) * m + ic);
          end
          GK_XOR:     grp_prod[a*ORDER_MAX + b] = ELEM_W'(a ^ b);
          GK_GARBAGE: grp_prod[a*ORDER_MAX + b] = ELEM_W'($urandom_range(0, top));
          default:    grp_prod[a*ORDER_MAX + b] = ELEM_W'((a + b) % n);
        endcase
      end
      case (kind)
        GK_DIHEDRAL: grp_inv[a] = ELEM_W'(ja ? a : (m - ia) % m);
        GK_XOR:      grp_inv[a] = ELEM_W'(a);
        GK_GARBAGE:  grp_inv[a] = ELEM_W'($urandom_range(0, top));
        default:     grp_inv[a] = ELEM_W'((n - a) % n);
      endcase
    end
    // A nearly proper group: a few entries point elsewhere, possibly outside the group.
    if (kind == GK_CORRUPT) begin
      repeat ($urandom_range(1, 3)) begin
        ia = $urandom_range(0, n - 1);
        ib = $urandom_range(0, n - 1);
        grp_prod[ia*ORDER_MAX + ib] = ELEM_W'($urandom_range(0, 63));
      end
      if ($urandom_range(0, 1) == 1) grp_inv[$urandom_range(0, n - 1)] = ELEM_W'(any_elem());
    end
  endfunction

  function automatic void load_group(int n);
    for (int a = 0; a < n; a++) begin
      for (int b = 0; b < n; b++) begin
        push_item(FN_PROD, a, b, grp_prod[a*ORDER_MAX + b], $urandom_range(0, 1));
      end
      push_item(FN_INV, a, any_elem(), grp_inv[a], $urandom_range(0, 1));
    end
  endfunction

  // Writes only the entries that a run reads when H is empty or the identity alone.
  function automatic void load_sparse(int n);
    int ai;
    for (int a = 0; a < n; a++) begin
      ai = grp_inv[a];
      push_item(FN_PROD, a, 0, grp_prod[a*ORDER_MAX], $urandom_range(0, 1));
      push_item(FN_INV, a, any_elem(), ai, $urandom_range(0, 1));
      if (ai != 0) begin
        push_item(FN_PROD, a, ai, grp_prod[a*ORDER_MAX + ai], $urandom_range(0, 1));
      end
    end
  endfunction

  // Closure of {e, g1, g2} under the product table, kept inside the group.
  function automatic logic [MASK_W-1:0] subgroup_closure(int g1, int g2, int n);
    logic [MASK_W-1:0] m, grown;
    int p;
    grown = 64'd1;
    grown[g1] = 1'b1;
    grown[g2] = 1'b1;
    do begin
      m = grown;
      for (int a = 0; a < n; a++) begin
        for (int b = 0; b < n; b++) begin
          p = grp_prod[a*ORDER_MAX + b];
          if (m[a] && m[b] && p < n) grown[p] = 1'b1;
        end
      end
    end while (grown != m);
    return m;
  endfunction

  // Moves H to a new subset and sometimes sets a stray bit beyond the order.
  function automatic void choose_subset(int n);
    logic [MASK_W-1:0] target;
    int r, k;
    target = grp_subset;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      target = subgroup_closure($urandom_range(0, n - 1),
                                ($urandom_range(0, 1) == 1) ? $urandom_range(0, n - 1) : 0, n);
    end else if (r < 6) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(0, n - 1);
        target[k] = !target[k];
      end
    end else if (r == 6) begin
      target = '0;
    end else if (r == 7) begin
      target = '1;
    end else begin
      target = {$urandom, $urandom};
    end
    for (int e = 0; e < n; e++) begin
      if (target[e] != grp_subset[e]) push_item(FN_SUBSET, e, any_elem(), any_elem(), target[e]);
    end
    if (n < ORDER_MAX && $urandom_range(0, 3) == 0) begin
      push_item(FN_SUBSET, $urandom_range(n, 63), any_elem(), any_elem(), $urandom_range(0, 1));
    end
  endfunction

  function automatic void pick_gaps();
    in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 14;
    out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
  endfunction

  // Waits until every item went in and every result came out, then lets loads settle.
  task automatic wait_idle();
    while (item_queue.size() != 0 || drv_busy || pending_norms.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic write_order(int v);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ORD_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    order_shadow = ORD_W'(v);
  endtask

  // One phase: set the order, optionally load a fresh group, then a series of runs.
  task automatic group_phase(int cfg_val, grp_kind_t kind, int runs, bit reload);
    int n;
    n = (cfg_val < 1) ? 1 : (cfg_val > ORDER_MAX) ? ORDER_MAX : cfg_val;
    write_order(cfg_val);
    if (reload) begin
      build_group(kind, n);
      load_group(n);
    end
    repeat (runs) begin
      choose_subset(n);
      push_item(FN_RUN, any_elem(), any_elem(), any_elem(), $urandom_range(0, 1));
    end
  endtask

  // Phase on sparsely loaded full size tables, with H empty or the identity alone.
  task automatic sparse_phase(int cfg_val, bit reload, grp_kind_t kind, int runs);
    logic [MASK_W-1:0] target;
    write_order(cfg_val);
    if (reload) begin
      build_group(kind, ORDER_MAX);
      load_sparse(ORDER_MAX);
    end
    repeat (runs) begin
      target = '0;
      target[0] = $urandom_range(0, 1);
      for (int e = 0; e < ORDER_MAX; e++) begin
        if (target[e] != grp_subset[e]) begin
          push_item(FN_SUBSET, e, any_elem(), any_elem(), target[e]);
        end
      end
      push_item(FN_RUN, any_elem(), any_elem(), any_elem(), $urandom_range(0, 1));
    end
  endtask

  initial begin
    int n, r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Order 1 from reset: empty H, H holding the identity, a stray bit past the order.
    push_item(FN_INV, 0, 0, 0, 1'b0);
    push_item(FN_PROD, 0, 0, 0, 1'b0);
    push_item(FN_RUN, 0, 0, 0, 1'b0);
    push_item(FN_SUBSET, 0, 0, 0, 1'b1);
    push_item(FN_SUBSET, 63, 63, 63, 1'b1);
    push_item(FN_RUN, 63, 63, 63, 1'b1);
    push_item(FN_PROD, 63, 63, 63, 1'b1);
    push_item(FN_SUBSET, 0, 0, 0, 1'b0);
    push_item(FN_RUN, 0, 0, 0, 1'b0);

    // Order 2: a proper table, then an inverse, a first product and a conjugate
    // each pointing outside the group.
    write_order(2);
    push_item(FN_PROD, 0, 1, 1, 1'b0);
    push_item(FN_PROD, 1, 0, 1, 1'b0);
    push_item(FN_PROD, 1, 1, 0, 1'b0);
    push_item(FN_INV, 1, 0, 1, 1'b0);
    push_item(FN_SUBSET, 1, 0, 0, 1'b1);
    push_item(FN_RUN, 0, 0, 0, 1'b0);
    push_item(FN_INV, 0, 0, 63, 1'b0);
    push_item(FN_RUN, 0, 0, 0, 1'b0);
    push_item(FN_INV, 0, 0, 0, 1'b0);
    push_item(FN_PROD, 0, 1, 62, 1'b0);
    push_item(FN_RUN, 0, 0, 0, 1'b0);
    push_item(FN_PROD, 0, 1, 1, 1'b0);
    push_item(FN_PROD, 1, 0, 5, 1'b0);
    push_item(FN_RUN, 0, 0, 0, 1'b0);
    push_item(FN_PROD, 1, 0, 1, 1'b0);

    // Receiver holds off while runs keep coming, so the engine backs up into its input.
    pick_gaps();
    group_phase(4, GK_DIHEDRAL, 8, 1'b1);
    hold_request = LONG_HOLD;

    // Random groups of mostly small orders.
    while (items_pushed < 400 || runs_pushed < 40) begin
      pick_gaps();
      r = $urandom_range(0, 19);
      n = (r < 16) ? $urandom_range(1, 8) : $urandom_range(9, 12);
      group_phase(n, pick_kind(n), $urandom_range(3, 8), 1'b1);
    end

    // Full size group, loaded back to back; then the order register past its range
    // on both sides, reusing the loaded tables.
    pick_gaps();
    in_gap_max = 0;
    sparse_phase(64, 1'b1, ($urandom_range(0, 1) == 1) ? GK_DIHEDRAL : GK_CYCLIC, 3);
    pick_gaps();
    sparse_phase(127, 1'b0, GK_CYCLIC, 2);
    sparse_phase(0, 1'b0, GK_CYCLIC, 2);

    wait_idle();
    repeat (END_DRAIN) @(posedge clk);
    if (norm_errors == 0 && pending_norms.size() == 0) begin
      $display("subgroup_normalizer_engine_unit: match");
    end else begin
      $display("subgroup_normalizer_engine_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sne_pkg.sv
rtl/core/sne_ctrl.sv
rtl/core/sne_datapath.sv
rtl/core/subgroup_normalizer_engine_unit.sv
tb/tb_subgroup_normalizer_engine_unit.sv
